>>> rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("shb assertion failed");
`define SHB_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("shb forbidden condition");
`else
`define SHB_ASSERT(lbl, prop)
`define SHB_NEVER(lbl, expr)
`endif
`endif

>>> rtl/shb_pkg.sv
// Types, constants and functions for the SHA-256 byte stream hasher
`default_nettype none
package shb_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } shb_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shb_out_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenOffset  = 6'd56;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0: round_k = 32'h428a2f98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hb5c0fbcf;  6'd3: round_k = 32'he9b5dba5;
      6'd4: round_k = 32'h3956c25b;  6'd5: round_k = 32'h59f111f1;
      6'd6: round_k = 32'h923f82a4;  6'd7: round_k = 32'hab1c5ed5;
      6'd8: round_k = 32'hd807aa98;  6'd9: round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/shb_stream_if.sv
// Valid/ready stream interface carrying one item payload
`default_nettype none
interface shb_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: byte gathering, padding, iterative round unit
// A byte is taken while idle; a byte that fills the block starts its compression
// (64 rounds on one shared round unit, then the chain add).
// End of message: pad, compress, and a further length block for a tail of 56+ bytes,
// then eight digest items, one per cycle the sink is ready. Not ready meanwhile.
// Reset (asynchronous, active low) clears the length and fill and loads the initial hash.
`default_nettype none
module sha256_byte_stream_hasher (
  input  wire         clk_i,
  input  wire         rst_ni,
  shb_stream_if.sink   in_i,
  shb_stream_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_ADD, ST_OUT
  } state_e;

  state_e      state_q, after_q;
  logic [31:0] w_q [shb_pkg::BlockWords];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q, cnt_q;
  logic [63:0] bits_q;
  logic [2:0]  idx_q;

  logic [31:0] s0w, s1w, wnew, sig0, sig1, chs, maj, t1, t2;
  logic [1:0]  lane;
  logic        in_acc, out_acc;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign lane    = ~fill_q[1:0];

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = (state_q == ST_OUT);
  assign out_o.data.digest_word = h_q[idx_q];
  assign out_o.data.word_index  = idx_q;
  assign out_o.data.last_word   = (idx_q == 3'd7);

  always_comb begin
    s0w  = shb_pkg::ror32(w_q[1], 7) ^ shb_pkg::ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1w  = shb_pkg::ror32(w_q[14], 17) ^ shb_pkg::ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0w + w_q[9] + s1w;
    sig1 = shb_pkg::ror32(v_q[4], 6) ^ shb_pkg::ror32(v_q[4], 11) ^ shb_pkg::ror32(v_q[4], 25);
    chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + sig1 + chs + shb_pkg::round_k(cnt_q) + w_q[0];
    sig0 = shb_pkg::ror32(v_q[0], 2) ^ shb_pkg::ror32(v_q[0], 13) ^ shb_pkg::ror32(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = sig0 + maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      bits_q  <= '0;
      idx_q   <= '0;
      for (int j = 0; j < shb_pkg::BlockWords; j++) w_q[j] <= '0;
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= '0;
        h_q[j] <= shb_pkg::init_hash(3'(j));
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.data.byte_valid) begin
              w_q[fill_q[5:2]][{lane, 3'b000} +: 8] <= in_i.data.data_byte;
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
              if (fill_q == 6'd63) begin
                for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
                cnt_q   <= '0;
                state_q <= ST_ROUND;
                after_q <= in_i.data.end_of_message ? ST_PAD : ST_IDLE;
              end else if (in_i.data.end_of_message) begin
                state_q <= ST_PAD;
              end
            end else if (in_i.data.end_of_message) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          for (int j = 0; j < shb_pkg::BlockWords; j++) begin
            for (int k = 0; k < 4; k++) begin
              if (6'(4 * j + k) == fill_q) begin
                w_q[j][8 * (3 - k) +: 8] <= shb_pkg::PadByte;
              end else if (6'(4 * j + k) > fill_q) begin
                w_q[j][8 * (3 - k) +: 8] <= 8'h00;
              end
            end
          end
          if (fill_q < shb_pkg::LenOffset) begin
            w_q[14] <= bits_q[63:32];
            w_q[15] <= bits_q[31:0];
            after_q <= ST_OUT;
          end else begin
            after_q <= ST_LEN;
          end
          for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
          cnt_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_LEN: begin
          for (int j = 0; j < 14; j++) w_q[j] <= '0;
          w_q[14] <= bits_q[63:32];
          w_q[15] <= bits_q[31:0];
          for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
          cnt_q   <= '0;
          after_q <= ST_OUT;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int j = 0; j < shb_pkg::BlockWords - 1; j++) w_q[j] <= w_q[j + 1];
          w_q[15] <= wnew;
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'(shb_pkg::Rounds - 1)) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
          idx_q   <= '0;
          state_q <= after_q;
        end
        ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              for (int j = 0; j < 8; j++) h_q[j] <= shb_pkg::init_hash(3'(j));
              fill_q  <= '0;
              bits_q  <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`include "sha256_byte_stream_hasher_assert.svh"
  `SHB_NEVER(a_no_overlap, in_i.ready && out_o.valid)
  `SHB_ASSERT(a_digest_continues, out_acc && !out_o.data.last_word |=> out_o.valid)
  `SHB_ASSERT(a_eom_busy, in_acc && in_i.data.end_of_message |=> !in_i.ready)
  `SHB_ASSERT(a_last_ends, out_acc && out_o.data.last_word |=> in_i.ready)

endmodule
`default_nettype wire
